// ===== src/nsmc_pkg.sv =====
// Shared constants, types and sign helpers for the nested sliding-mode controller.
package nsmc_pkg;

  localparam int DATA_WIDTH_DEF = 24;
  localparam int FRAC_BITS      = 12;
  localparam int GAIN_RESET     = 4096;
  localparam int KSCALE         = 531441;  // 3^12
  localparam int KSCALE_W       = 20;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_YAW = 2'd3
  } axis_t;

  localparam logic [1:0] REG_GAIN_X   = 2'd0;
  localparam logic [1:0] REG_GAIN_Y   = 2'd1;
  localparam logic [1:0] REG_GAIN_Z   = 2'd2;
  localparam logic [1:0] REG_GAIN_YAW = 2'd3;

  typedef logic signed [1:0] sgn_t;

  localparam sgn_t SGN_POS  = 2'sb01;
  localparam sgn_t SGN_NEG  = 2'sb11;
  localparam sgn_t SGN_ZERO = 2'sb00;

  // sign of (a + b) where gt/lt compare equal powers of |a| and |b|
  function automatic sgn_t resolve(sgn_t sa, sgn_t sb, logic gt, logic lt);
    sgn_t r;
    if (sb == SGN_ZERO) r = sa;
    else if (sa == SGN_ZERO || sa == sb) r = sb;
    else if (gt) r = sa;
    else if (lt) r = sb;
    else r = SGN_ZERO;
    return r;
  endfunction

endpackage

// ===== src/nested_sliding_mode_control.sv =====
// Top level: nested higher-order sliding-mode switching stage, one axis per transaction.
//
//  channel | direction | contents
//  in_     | slave     | tuser: axis; tdata: meas pos/vel/acc/jerk, nom pos/vel/acc/jerk, ref
//  out_    | master    | tdata: control_value, switch_sign, saturated
//  cfg_    | write     | cfg_addr selects gain_x/y/z/yaw, cfg_wdata is the gain
//
// One transaction enters per cycle unless out_ stalls. There are 25 register stages; the longest
// path is the jerk^12 power chain (eleven two-stage multiply steps). Every stage moves on one
// enable, so a stall on out_ freezes the whole pipeline and in_tready drops with it.
// Synchronous reset clears the valid bits and loads every gain with 1.0.
module nested_sliding_mode_control #(
  parameter int DATA_WIDTH = nsmc_pkg::DATA_WIDTH_DEF,
  localparam int IN_TW  = ((9 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((DATA_WIDTH + 3 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // meas_pos, meas_vel, meas_acc, meas_jerk, nom_pos, nom_vel, nom_acc, nom_jerk,
  // reference_value (lowest first)
  input  logic [IN_TW-1:0]      in_tdata,
  // axis
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // control_value, switch_sign, saturated (lowest first)
  output logic [OUT_TW-1:0]     out_tdata,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [DATA_WIDTH-2:0] cfg_wdata
);

  import nsmc_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int MW  = W + 1;
  localparam int GW  = W - 1;
  localparam int F   = FRAC_BITS;
  localparam int TW  = 6 * MW + 2;
  localparam int QW  = TW + KSCALE_W;
  localparam int UW  = 4 * MW + 1;
  localparam int LAT = 25;

  function automatic logic signed [MW-1:0] diff(logic [W-1:0] a, logic [W-1:0] b);
    return $signed({a[W-1], a}) - $signed({b[W-1], b});
  endfunction

  function automatic sgn_t sgn_of(logic signed [MW-1:0] e);
    sgn_t r;
    if (e[MW-1]) r = SGN_NEG;
    else if (e != '0) r = SGN_POS;
    else r = SGN_ZERO;
    return r;
  endfunction

  function automatic logic [MW-1:0] mag_of(logic signed [MW-1:0] e);
    return e[MW-1] ? MW'(-e) : MW'(e);
  endfunction

  logic en;
  logic [LAT-1:0] vld_r;
  logic [GW-1:0] gain_r [4];

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) gain_r[i] <= GW'(GAIN_RESET);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN_X:   gain_r[0] <= cfg_wdata;
        REG_GAIN_Y:   gain_r[1] <= cfg_wdata;
        REG_GAIN_Z:   gain_r[2] <= cfg_wdata;
        REG_GAIN_YAW: gain_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 0: errors
  logic signed [MW-1:0] ep, ev, ea, ej;
  logic [MW-1:0] mp_r, mv_r, ma_r, mj_r;
  sgn_t sp_r, sv_r, sa_r, sj_r;
  logic [1:0] axis_r;
  logic [W-1:0] ref_r;
  logic [GW-1:0] gain0_r;

  assign ep = diff(in_tdata[0*W +: W], in_tdata[4*W +: W]);
  assign ev = diff(in_tdata[1*W +: W], in_tdata[5*W +: W]);
  assign ea = diff(in_tdata[2*W +: W], in_tdata[6*W +: W]);
  assign ej = diff(in_tdata[3*W +: W], in_tdata[7*W +: W]);

  always_ff @(posedge clk) begin
    if (en) begin
      mp_r    <= mag_of(ep);
      mv_r    <= mag_of(ev);
      ma_r    <= mag_of(ea);
      mj_r    <= mag_of(ej);
      sp_r    <= sgn_of(ep);
      sv_r    <= sgn_of(ev);
      sa_r    <= sgn_of(ea);
      sj_r    <= sgn_of(ej);
      axis_r  <= in_tuser;
      ref_r   <= in_tdata[8*W +: W];
      gain0_r <= gain_r[in_tuser];
    end
  end

  // power chains
  logic [12*MW-1:0] j12;
  logic [6*MW-1:0]  a6;
  logic [4*MW-1:0]  v4, v4d;
  logic [3*MW-1:0]  s3, s3d;
  logic [2*MW-1:0]  v2;

  nsmc_pow #(.BW(MW), .EXP(12)) u_pow_j (.clk(clk), .en(en), .base(mj_r), .pw(j12));
  nsmc_pow #(.BW(MW), .EXP(6))  u_pow_a (.clk(clk), .en(en), .base(ma_r), .pw(a6));
  nsmc_pow #(.BW(MW), .EXP(4))  u_pow_v (.clk(clk), .en(en), .base(mv_r), .pw(v4));
  nsmc_pow #(.BW(MW), .EXP(3))  u_pow_s (.clk(clk), .en(en), .base(mp_r), .pw(s3));
  nsmc_pow #(.BW(MW), .EXP(2))  u_pow_y (.clk(clk), .en(en), .base(mv_r), .pw(v2));

  nsmc_dly #(.W(4*MW), .D(4)) u_dly_v4 (.clk(clk), .en(en), .din(v4), .dout(v4d));
  nsmc_dly #(.W(3*MW), .D(6)) u_dly_s3 (.clk(clk), .en(en), .din(s3), .dout(s3d));

  // yaw rule at stage 2
  logic [MW-1:0] mp2;
  logic [3:0] sg2;
  logic [2*MW-1:0] yq;
  sgn_t ys_r, ys22;

  nsmc_dly #(.W(MW), .D(2)) u_dly_mp2 (.clk(clk), .en(en), .din(mp_r), .dout(mp2));
  nsmc_dly #(.W(4), .D(2)) u_dly_sg2 (.clk(clk), .en(en), .din({sv_r, sp_r}), .dout(sg2));

  assign yq = (2*MW)'(mp2) << F;

  always_ff @(posedge clk) begin
    if (en) ys_r <= resolve(sgn_t'(sg2[3:2]), sgn_t'(sg2[1:0]), v2 > yq, v2 < yq);
  end

  nsmc_dly #(.W(2), .D(19)) u_dly_ys (.clk(clk), .en(en), .din(ys_r), .dout(ys22));

  // stage 10: sums and first compare
  logic [TW-1:0] t_r;
  logic [UW-1:0] u_r;
  logic [6*MW-1:0] a6_r;
  logic c1gt_r, c1lt_r;
  logic [4*MW-1:0] q1;

  assign q1 = (4*MW)'(s3d) << (F - 4);

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= TW'(a6) + (TW'(v4d) << (2*F)) + (TW'(s3d) << (3*F));
      u_r    <= UW'(v4d) + (UW'(s3d) << F);
      a6_r   <= a6;
      c1gt_r <= v4d > q1;
      c1lt_r <= v4d < q1;
    end
  end

  // stage 11: inner signs
  logic [5:0] sg11;
  logic [6*MW-1:0] q2;
  sgn_t t1, t2_r, t2d;

  nsmc_dly #(.W(6), .D(11)) u_dly_sg11 (
    .clk(clk), .en(en), .din({sa_r, sv_r, sp_r}), .dout(sg11)
  );

  assign q2 = (6*MW)'(u_r) << (2*F);
  assign t1 = resolve(sgn_t'(sg11[3:2]), sgn_t'(sg11[1:0]), c1gt_r, c1lt_r);

  always_ff @(posedge clk) begin
    if (en) t2_r <= resolve(sgn_t'(sg11[5:4]), t1, a6_r > q2, a6_r < q2);
  end

  nsmc_dly #(.W(2), .D(10)) u_dly_t2 (.clk(clk), .en(en), .din(t2_r), .dout(t2d));

  // scaled bound for the outer compare
  logic [QW-1:0] qk, qkd;

  nsmc_mulw #(.AW(TW), .BW(KSCALE_W)) u_mul_k (
    .clk(clk), .en(en), .a(t_r), .b(KSCALE_W'(KSCALE)), .prod(qk)
  );

  nsmc_dly #(.W(QW), .D(9)) u_dly_qk (.clk(clk), .en(en), .din(qk), .dout(qkd));

  // stage 22: outer sign
  sgn_t sj22, s_r;
  logic [1:0] axis22;
  logic [12*MW-1:0] q3;

  nsmc_dly #(.W(2), .D(22)) u_dly_sj (.clk(clk), .en(en), .din(sj_r), .dout(sj22));
  nsmc_dly #(.W(2), .D(22)) u_dly_ax (.clk(clk), .en(en), .din(axis_r), .dout(axis22));

  assign q3 = (12*MW)'(qkd) << (6*F);

  always_ff @(posedge clk) begin
    if (en) begin
      if (axis22 == AXIS_YAW) s_r <= ys22;
      else s_r <= resolve(sj22, t2d, j12 > q3, j12 < q3);
    end
  end

  // stage 23: apply gain and clip
  logic [W+GW-1:0] rg23;
  logic signed [W+1:0] uval, gs, hi, lo;
  logic [W-1:0] cv_r;
  sgn_t so_r;
  logic sat_r;

  nsmc_dly #(.W(W+GW), .D(23)) u_dly_rg (
    .clk(clk), .en(en), .din({ref_r, gain0_r}), .dout(rg23)
  );

  always_comb begin
    hi = (W+2)'((64'sd1 <<< (W-1)) - 64'sd1);
    lo = -hi - (W+2)'(1);
    gs = $signed({3'b000, rg23[GW-1:0]});
    uval = $signed({{2{rg23[W+GW-1]}}, rg23[W+GW-1:GW]});
    if (s_r == SGN_POS) uval = uval - gs;
    else if (s_r == SGN_NEG) uval = uval + gs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      so_r <= s_r;
      if (uval > hi) begin
        cv_r  <= hi[W-1:0];
        sat_r <= 1'b1;
      end else if (uval < lo) begin
        cv_r  <= lo[W-1:0];
        sat_r <= 1'b1;
      end else begin
        cv_r  <= uval[W-1:0];
        sat_r <= 1'b0;
      end
    end
  end

  assign out_tdata = OUT_TW'({sat_r, so_r, cv_r});

endmodule

// ===== src/nsmc_dly.sv =====
// Enabled shift-register delay line.
module nsmc_dly #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < D; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[D-1];

endmodule

// ===== src/nsmc_mulw.sv =====
// Wide-by-narrow multiplier: registered limb products, then one registered wide add.
module nsmc_mulw #(
  parameter int AW = 48,
  parameter int BW = 24
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] prod
);

  localparam int NL = (AW + BW - 1) / BW;
  localparam int VW = (NL + 1) * BW;

  logic [NL*BW-1:0] a_ext;
  logic [2*BW-1:0]  pp_r [NL];
  logic [VW-1:0]    ev, od, sum;

  assign a_ext = (NL*BW)'(a);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NL; i++) pp_r[i] <= a_ext[i*BW +: BW] * b;
    end
  end

  // even and odd limb products do not overlap among themselves
  always_comb begin
    ev = '0;
    od = '0;
    for (int i = 0; i < NL; i++) begin
      if (i % 2 == 0) ev[i*BW +: 2*BW] = pp_r[i];
      else            od[i*BW +: 2*BW] = pp_r[i];
    end
    sum = ev + od;
  end

  always_ff @(posedge clk) begin
    if (en) prod <= sum[AW+BW-1:0];
  end

endmodule

// ===== src/nsmc_pow.sv =====
// Integer power unit: repeated multiply by the base, two stages per step.
module nsmc_pow #(
  parameter int BW  = 25,
  parameter int EXP = 2
) (
  input  logic              clk,
  input  logic              en,
  input  logic [BW-1:0]     base,
  output logic [BW*EXP-1:0] pw
);

  localparam int PW = BW * EXP;

  logic [PW-1:0] acc [EXP];
  logic [BW-1:0] bs  [EXP];

  assign acc[0] = PW'(base);
  assign bs[0]  = base;

  for (genvar k = 0; k < EXP - 1; k++) begin : g_step
    logic [PW+BW-1:0] prod;

    nsmc_mulw #(.AW(PW), .BW(BW)) u_mul (
      .clk  (clk),
      .en   (en),
      .a    (acc[k]),
      .b    (bs[k]),
      .prod (prod)
    );

    assign acc[k+1] = prod[PW-1:0];

    if (k < EXP - 2) begin : g_base
      logic [BW-1:0] b1_r, b2_r;
      always_ff @(posedge clk) begin
        if (en) begin
          b1_r <= bs[k];
          b2_r <= b1_r;
        end
      end
      assign bs[k+1] = b2_r;
    end
  end

  assign pw = acc[EXP-1];

endmodule
